[src/rdb_pkg.sv]
// rdb_pkg: shared constants for the reversible deque buffer
// command and status codes, default sizes; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rdb_pkg;

   // default sizes
   localparam int DEPTH_DEF     = 64;
   localparam int ELEM_BITS_DEF = 8;

   // fixed field widths
   localparam int OP_BITS     = 2;
   localparam int ITEM_BITS   = 8;
   localparam int STATUS_BITS = 2;

   // command codes
   localparam logic [OP_BITS-1:0] OP_LOAD    = 2'd0;
   localparam logic [OP_BITS-1:0] OP_REVERSE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_DELETE  = 2'd2;
   localparam logic [OP_BITS-1:0] OP_FINISH  = 2'd3;

   // case status codes
   localparam logic [STATUS_BITS-1:0] ST_OK           = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY_DELETE = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_OVERFLOW     = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_UNUSED       = 2'd3;

endpackage : rdb_pkg

`default_nettype wire

[src/reversible_deque_buffer_unit.sv]
// reversible_deque_buffer_unit: top level of the reversible deque buffer
// depends on rdb_pkg, rdb_ram and rdb_ctrl
`timescale 1ns / 1ps
`default_nettype none

// Bounded deque of up to DEPTH elements with a reverse flag, held as a ring in
// one memory with a registered read. Each request beat carries a command in
// req_tuser: load appends req_tdata at the back, reverse toggles the flag,
// delete drops the front (the back while reversed), finish emits the list.
// Load, reverse and delete never stall the command side, so such beats are
// taken back to back. A delete on an empty list latches an error and later
// commands are ignored until finish; a load into a full list is dropped and
// flagged as overflow. Finish emits one response beat per element in the
// current order (tlast on the final one), or a single error beat, or a single
// empty-marker beat; it then clears the list, the flag and the status. While a
// finish run is in progress req_tready is low: one element leaves the memory
// per cycle while rsp_tready does not stall, bounded by the single memory read
// port. The output register lets the next command beat in while the final
// response beat still waits. No clearing pass follows reset; memory contents
// are only read where they were written.
module reversible_deque_buffer_unit
   import rdb_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int ELEM_BITS = ELEM_BITS_DEF,
   localparam int REQ_DATA_W = ((ELEM_BITS + 7) / 8) * 8,
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // command beats
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [REQ_DATA_W-1:0]   req_tdata,   // value, zero padded
   input  wire logic [OP_BITS-1:0]      req_tuser,   // op
   // result beats
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic      [ITEM_BITS-1:0]    rsp_tdata,   // item
   output logic      [STATUS_BITS:0]    rsp_tuser,   // status, list_empty
   output logic                         rsp_tlast    // last
);

   // memory connections
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [ELEM_BITS-1:0] wr_data;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [ELEM_BITS-1:0] rd_data;

   logic [STATUS_BITS-1:0] rsp_status;
   logic                   rsp_empty;

   // element ring
   rdb_ram #(
      .WIDTH (ELEM_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // commands, pointers and drain
   rdb_ctrl #(
      .DEPTH     (DEPTH),
      .ELEM_BITS (ELEM_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (req_tuser),
      .req_value  (req_tdata[ELEM_BITS-1:0]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_item   (rsp_tdata),
      .rsp_status (rsp_status),
      .rsp_empty  (rsp_empty),
      .rsp_last   (rsp_tlast),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   // status in the low bits, empty marker flag above it
   assign rsp_tuser = {rsp_empty, rsp_status};

endmodule : reversible_deque_buffer_unit

`default_nettype wire

[src/rdb_ram.sv]
// rdb_ram: generic single-write, single-read memory with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rdb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : rdb_ram

`default_nettype wire

[src/rdb_ctrl.sv]
// rdb_ctrl: command handling, ring pointers and finish drain sequencer
// depends on rdb_pkg; drives the element memory rdb_ram
`timescale 1ns / 1ps
`default_nettype none

module rdb_ctrl
   import rdb_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int ELEM_BITS = ELEM_BITS_DEF,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // command side
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [OP_BITS-1:0]     req_op,
   input  wire logic [ELEM_BITS-1:0]   req_value,
   // result side
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic      [ITEM_BITS-1:0]   rsp_item,
   output logic      [STATUS_BITS-1:0] rsp_status,
   output logic                        rsp_empty,
   output logic                        rsp_last,
   // element memory
   output logic                        wr_en,
   output logic      [IDX_W-1:0]       wr_addr,
   output logic      [ELEM_BITS-1:0]   wr_data,
   output logic                        rd_en,
   output logic      [IDX_W-1:0]       rd_addr,
   input  wire logic [ELEM_BITS-1:0]   rd_data
);

   localparam logic S_IDLE  = 1'b0;
   localparam logic S_DRAIN = 1'b1;

   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   // ring position of idx + off, both in range so one subtract wraps it
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(idx) + (CNT_W + 1)'(off);
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return IDX_W'(sum);
   endfunction

   logic                   state_ff, state_in;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   rev_ff, rev_in;
   logic [STATUS_BITS-1:0] cstat_ff, cstat_in;
   // drain sequencer
   logic [IDX_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       remain_ff, remain_in;
   logic                   marker_ff, marker_in;
   logic [STATUS_BITS-1:0] run_stat_ff, run_stat_in;
   logic                   run_empty_ff, run_empty_in;
   logic                   pend_ff, pend_in;
   logic                   pend_last_ff, pend_last_in;
   // output register
   logic                   out_valid_ff, out_valid_in;
   logic [ITEM_BITS-1:0]   out_item_ff, out_item_in;
   logic [STATUS_BITS-1:0] out_stat_ff, out_stat_in;
   logic                   out_empty_ff, out_empty_in;
   logic                   out_last_ff, out_last_in;

   logic accept;
   logic out_free;
   logic moved;
   logic issue;
   logic marker_go;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;
   // memory read data moves into the output register
   assign moved     = pend_ff && out_free;
   // a read may start once the held read data is free or moving
   assign issue     = (state_ff == S_DRAIN) && (remain_ff != '0) && (!pend_ff || moved);
   assign marker_go = (state_ff == S_DRAIN) && marker_ff && out_free;

   assign wr_data = req_value;
   assign rd_en   = issue;
   assign rd_addr = rd_ptr_ff;

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      rev_in       = rev_ff;
      cstat_in     = cstat_ff;
      rd_ptr_in    = rd_ptr_ff;
      remain_in    = remain_ff;
      marker_in    = marker_ff;
      run_stat_in  = run_stat_ff;
      run_empty_in = run_empty_ff;
      wr_en        = 1'b0;
      wr_addr      = wrap_add(head_ff, count_ff);

      if (accept) begin
         if (req_op == OP_FINISH) begin
            run_stat_in  = cstat_ff;
            run_empty_in = 1'b0;
            if (cstat_ff == ST_EMPTY_DELETE) begin
               marker_in = 1'b1;
            end else if (count_ff == '0) begin
               marker_in    = 1'b1;
               run_empty_in = 1'b1;
            end else begin
               remain_in = count_ff;
               rd_ptr_in = rev_ff ? wrap_add(head_ff, count_ff - CNT_W'(1)) : head_ff;
            end
            head_in  = '0;
            count_in = '0;
            rev_in   = 1'b0;
            cstat_in = ST_OK;
         end else if (cstat_ff != ST_EMPTY_DELETE) begin
            case (req_op)
               OP_LOAD: begin
                  if (count_ff == FULL_CNT) begin
                     if (cstat_ff == ST_OK) begin
                        cstat_in = ST_OVERFLOW;
                     end
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               OP_REVERSE: begin
                  rev_in = !rev_ff;
               end
               OP_DELETE: begin
                  if (count_ff == '0) begin
                     cstat_in = ST_EMPTY_DELETE;
                  end else begin
                     if (!rev_ff) begin
                        head_in = wrap_add(head_ff, CNT_W'(1));
                     end
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               default: begin
               end
            endcase
         end
      end

      if (issue) begin
         remain_in = remain_ff - CNT_W'(1);
      end
   end

   // read pointer direction is fixed for the whole run
   logic run_rev_ff, run_rev_in;

   always_comb begin
      run_rev_in   = run_rev_ff;
      pend_in      = issue || (pend_ff && !moved);
      pend_last_in = pend_last_ff;
      if (accept && (req_op == OP_FINISH)) begin
         run_rev_in = rev_ff;
      end
      if (issue) begin
         pend_last_in = (remain_ff == CNT_W'(1));
      end
   end

   logic [IDX_W-1:0] ptr_step;

   always_comb begin
      if (run_rev_ff) begin
         ptr_step = (rd_ptr_ff == '0) ? LAST_IDX : rd_ptr_ff - IDX_W'(1);
      end else begin
         ptr_step = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + IDX_W'(1);
      end
   end

   logic [IDX_W-1:0] rd_ptr_next;
   assign rd_ptr_next = issue ? ptr_step : rd_ptr_in;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      out_stat_in  = out_stat_ff;
      out_empty_in = out_empty_ff;
      out_last_in  = out_last_ff;
      if (moved) begin
         out_valid_in = 1'b1;
         out_item_in  = ITEM_BITS'(rd_data);
         out_stat_in  = run_stat_ff;
         out_empty_in = 1'b0;
         out_last_in  = pend_last_ff;
      end else if (marker_go) begin
         out_valid_in = 1'b1;
         out_item_in  = '0;
         out_stat_in  = run_stat_ff;
         out_empty_in = run_empty_ff;
         out_last_in  = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   logic marker_next;
   assign marker_next = marker_go ? 1'b0 : marker_in;

   // run is over once nothing is left to read, hold or mark
   always_comb begin
      state_in = state_ff;
      if (accept && (req_op == OP_FINISH)) begin
         state_in = S_DRAIN;
      end else if ((state_ff == S_DRAIN) && (remain_in == '0) && !pend_in && !marker_next) begin
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         cstat_ff     <= ST_OK;
         remain_ff    <= '0;
         marker_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         cstat_ff     <= cstat_in;
         remain_ff    <= remain_in;
         marker_ff    <= marker_next;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_next;
      run_rev_ff   <= run_rev_in;
      run_stat_ff  <= run_stat_in;
      run_empty_ff <= run_empty_in;
      pend_last_ff <= pend_last_in;
      out_item_ff  <= out_item_in;
      out_stat_ff  <= out_stat_in;
      out_empty_ff <= out_empty_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_item   = out_item_ff;
   assign rsp_status = out_stat_ff;
   assign rsp_empty  = out_empty_ff;
   assign rsp_last   = out_last_ff;

endmodule : rdb_ctrl

`default_nettype wire

[src/rdb_checker.sv]
// rdb_checker: port-level checks for reversible_deque_buffer_unit
// depends on rdb_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module rdb_checker
   import rdb_pkg::*;
#(
   parameter int ELEM_BITS = ELEM_BITS_DEF,
   localparam int REQ_DATA_W = ((ELEM_BITS + 7) / 8) * 8
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [REQ_DATA_W-1:0] req_tdata,
   input wire logic [OP_BITS-1:0]    req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [ITEM_BITS-1:0]  rsp_tdata,
   input wire logic [STATUS_BITS:0]  rsp_tuser,
   input wire logic                  rsp_tlast
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // a finish closes the command side in the cycle after it is taken
   a_finish_stalls: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_FINISH) |=> !req_tready)
      else $error("command taken right after finish");

   // empty marker is a lone zero beat
   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[STATUS_BITS] |-> rsp_tlast && (rsp_tdata == '0)
         && (rsp_tuser[STATUS_BITS-1:0] != ST_EMPTY_DELETE))
      else $error("bad empty marker");

   // error result is a lone zero beat
   a_error_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[STATUS_BITS-1:0] == ST_EMPTY_DELETE)
         |-> rsp_tlast && (rsp_tdata == '0) && !rsp_tuser[STATUS_BITS])
      else $error("bad error beat");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[STATUS_BITS-1:0] != ST_UNUSED)
      else $error("unused status code");

endmodule : rdb_checker

bind reversible_deque_buffer_unit rdb_checker #(
   .ELEM_BITS (ELEM_BITS)
) u_rdb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
